### sv/eelmm_pkg.sv
// Package for the element edge length min/max block.
// Holds widths, register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eelmm_pkg;

  // Coordinate width taken from each 24-bit field (range 8..24)
  localparam int COORD_WIDTH = 24;
  localparam int FIELD_W     = 24;
  localparam int SQ_W        = 50;
  localparam int LEN_W       = 25;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int ROOT_STEPS  = LEN_W;
  localparam int STEP_CNT_W  = $clog2(ROOT_STEPS);

  // APB register map
  localparam int  CFG_ADDR_W   = 3;
  localparam int  CFG_DATA_W   = 32;
  localparam logic REG_NUM_DIMS = 1'b0;
  localparam logic [1:0] NUM_DIMS_RESET = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_DONE
  } eelmm_state_t;

endpackage

`default_nettype wire

### sv/element_edge_length_min_max.sv
// Element edge length min/max: one mesh edge per input transaction.
// A non-final edge holds in_ready low after accept while it is squared and compared.
// A final edge then adds two square roots, min first and max second, before out_valid
// rises. A new edge is taken only once the last is through, as the block shares its
// multiplier (one dimension per cycle) and its one-bit-per-cycle root unit.
// Reset (rst_n low, synchronous) clears the running state and sets num_dims to 3.
`timescale 1ns / 1ps
`default_nettype none

module element_edge_length_min_max
  import eelmm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FIELD_W-1:0]    in_a_x,
  input  wire logic [FIELD_W-1:0]    in_a_y,
  input  wire logic [FIELD_W-1:0]    in_a_z,
  input  wire logic [FIELD_W-1:0]    in_b_x,
  input  wire logic [FIELD_W-1:0]    in_b_y,
  input  wire logic [FIELD_W-1:0]    in_b_z,
  input  wire logic                  in_last_edge,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LEN_W-1:0]           out_min_len,
  output logic [LEN_W-1:0]           out_max_len,
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  // |a - b| over the low COORD_WIDTH bits, taken as two's complement
  function automatic logic [COORD_WIDTH-1:0] abs_diff(input logic [FIELD_W-1:0] a,
                                                      input logic [FIELD_W-1:0] b);
    logic signed [COORD_WIDTH:0] sa;
    logic signed [COORD_WIDTH:0] sb;
    logic signed [COORD_WIDTH:0] d;
    logic        [COORD_WIDTH:0] mag;
    sa  = signed'({a[COORD_WIDTH-1], a[COORD_WIDTH-1:0]});
    sb  = signed'({b[COORD_WIDTH-1], b[COORD_WIDTH-1:0]});
    d   = sa - sb;
    mag = d[COORD_WIDTH] ? unsigned'(-d) : unsigned'(d);
    return mag[COORD_WIDTH-1:0];
  endfunction

  eelmm_state_t state_r, state_nxt;

  logic [1:0]             num_dims_r;
  logic [COORD_WIDTH-1:0] diff_r [3];
  logic                   last_r;
  logic                   first_r;
  logic [1:0]             dim_cnt_r;
  logic [PROD_W-1:0]      prod_r;
  logic [SQ_W-1:0]        acc_r;
  logic [SQ_W-1:0]        min_sq_r;
  logic [SQ_W-1:0]        max_sq_r;
  logic                   root_sel_r;
  logic [STEP_CNT_W-1:0]  step_r;
  logic [SQ_W-1:0]        rem_r;
  logic [SQ_W-1:0]        root_r;
  logic [SQ_W-1:0]        bit_r;
  logic [LEN_W-1:0]       min_len_r;
  logic                   out_valid_r;
  logic [LEN_W-1:0]       out_min_r;
  logic [LEN_W-1:0]       out_max_r;

  logic                   in_fire;
  logic                   cfg_wr;
  logic                   out_free;
  logic [COORD_WIDTH-1:0] mul_op;
  logic [SQ_W-1:0]        trial;
  logic                   root_take;

  assign in_fire   = in_valid && in_ready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free  = !out_valid_r || out_ready;
  assign mul_op    = diff_r[dim_cnt_r];
  assign trial     = root_r + bit_r;
  assign root_take = rem_r >= trial;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == {(CFG_ADDR_W-2){REG_NUM_DIMS}})
                      ? {{(CFG_DATA_W-2){1'b0}}, num_dims_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= NUM_DIMS_RESET;
    end else if (cfg_wr &&
                 cfg_paddr[CFG_ADDR_W-1:2] == {(CFG_ADDR_W-2){REG_NUM_DIMS}}) begin
      num_dims_r <= cfg_pwdata[1:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (dim_cnt_r == num_dims_r) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = last_r ? ST_ROOT_LOAD : ST_IDLE;
      end
      ST_ROOT_LOAD: begin
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (step_r == STEP_CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = root_sel_r ? ST_DONE : ST_ROOT_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      root_sel_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_UPDATE) first_r <= last_r;
      if (state_r == ST_ROOT && step_r == STEP_CNT_W'(ROOT_STEPS - 1)) begin
        root_sel_r <= !root_sel_r;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: capture, shared multiply/accumulate, min/max, shared root
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          diff_r[0] <= abs_diff(in_a_x, in_b_x);
          diff_r[1] <= abs_diff(in_a_y, in_b_y);
          diff_r[2] <= abs_diff(in_a_z, in_b_z);
          last_r    <= in_last_edge;
          dim_cnt_r <= 2'd0;
          acc_r     <= '0;
        end
      end
      ST_SQUARE: begin
        // product of the previous cycle lands in the sum
        if (dim_cnt_r != 2'd0) acc_r <= acc_r + SQ_W'(prod_r);
        if (dim_cnt_r != num_dims_r) begin
          prod_r    <= mul_op * mul_op;
          dim_cnt_r <= dim_cnt_r + 2'd1;
        end
      end
      ST_UPDATE: begin
        if (first_r) begin
          min_sq_r <= acc_r;
          max_sq_r <= acc_r;
        end else begin
          if (acc_r < min_sq_r) min_sq_r <= acc_r;
          if (acc_r > max_sq_r) max_sq_r <= acc_r;
        end
      end
      ST_ROOT_LOAD: begin
        rem_r  <= root_sel_r ? max_sq_r : min_sq_r;
        root_r <= '0;
        bit_r  <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
        step_r <= '0;
      end
      ST_ROOT: begin
        if (root_take) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + STEP_CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_min_r <= min_len_r;
          out_max_r <= root_r[LEN_W-1:0];
        end
      end
      default: ;
    endcase
    // keep the first root while the second one runs
    if (state_r == ST_ROOT_LOAD && root_sel_r) min_len_r <= root_r[LEN_W-1:0];
  end

  assign out_valid   = out_valid_r;
  assign out_min_len = out_min_r;
  assign out_max_len = out_max_r;

endmodule

`default_nettype wire

### sv/eelmm_checker.sv
// Port-level checker for element_edge_length_min_max, bound to the top level.
// Depends on eelmm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module eelmm_checker
  import eelmm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [LEN_W-1:0]      out_min_len,
  input wire logic [LEN_W-1:0]      out_max_len
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_min_len) && $stable(out_max_len))
    else $error("result payload changed while stalled");

  // shortest edge never exceeds longest edge
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_len <= out_max_len)
    else $error("min_len above max_len");

  // block is not ready in the cycle after taking an edge
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind element_edge_length_min_max eelmm_checker u_eelmm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_min_len (out_min_len),
  .out_max_len (out_max_len)
);

`default_nettype wire
